FILE: hdl/sirt_pkg.sv
// Package for the signed integer to radix text converter.
// Holds widths, character codes, the digit-to-ASCII function and the
// command and status types shared by the controller and the datapath.
package sirt_pkg;

    // Default width of the value to convert.
    localparam int VALUE_BITS_DEFAULT = 32;

    // Fixed field widths.
    localparam int RADIX_W = 8;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 7;

    // Accepted radix range.
    localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd36;

    // ASCII codes used on the output.
    localparam logic [CHAR_W-1:0] ASCII_NUL     = 7'h00;
    localparam logic [CHAR_W-1:0] ASCII_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] DECIMAL_SPAN  = 7'd10;

    // Source of the character shown on the output channel.
    typedef enum logic [1:0] {
        OUT_SEL_DIGIT = 2'd0,
        OUT_SEL_SIGN  = 2'd1,
        OUT_SEL_BAD   = 2'd2
    } out_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     div_step;
        logic     rd_en;
        logic     ptr_dec;
        out_sel_t out_sel;
    } sirt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_bad;
        logic negative;
        logic last_bit;
        logic quo_zero;
        logic ptr_last;
    } sirt_status_t;

    // Maps a digit value 0..35 to '0'-'9' or 'a'-'z'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_W'(10))
            return ASCII_ZERO + {1'b0, d};
        else
            return ASCII_LOWER_A + {1'b0, d} - DECIMAL_SPAN;
    endfunction

endpackage

FILE: hdl/sirt_in_if.sv
// Input channel interface: one value and radix per transaction.
// Depends on sirt_pkg for the radix width.
interface sirt_in_if
    import sirt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic        [RADIX_W-1:0]    radix;

    modport source (output valid, output value, output radix, input ready);
    modport sink   (input valid, input value, input radix, output ready);
endinterface

FILE: hdl/sirt_out_if.sv
// Output channel interface: one ASCII character per transaction.
// Depends on sirt_pkg for the character width.
interface sirt_out_if
    import sirt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last_char;
    logic              bad_radix;

    modport source (output valid, output character, output last_char, output bad_radix,
                    input ready);
    modport sink   (input valid, input character, input last_char, input bad_radix,
                    output ready);
endinterface

FILE: hdl/signed_integer_to_radix_text_top.sv
// Signed integer to radix text converter, top level; one conversion at a time.
// After acceptance the bit-serial divider works out the digits into the digit store;
// then a minus sign is emitted for a negative value, and each digit is read from the
// store and then emitted, most significant first. Output stalls hold the emitting state.
// A bad radix gives a single NUL character flagged as bad.
// Asynchronous active-low reset returns the block to idle; the digit store is not cleared.
module signed_integer_to_radix_text_top
    import sirt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)(
    input logic        clk,
    input logic        rst_n,
    sirt_in_if.sink    number,
    sirt_out_if.source text
);
    sirt_cmd_t    cmd;
    sirt_status_t status;
    logic         in_ready;
    logic         out_valid;

    // Sequencing.
    sirt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (number.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (text.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Division, digit storage and character generation.
    sirt_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (number.value),
        .radix     (number.radix),
        .cmd       (cmd),
        .status    (status),
        .character (text.character),
        .last_char (text.last_char),
        .bad_radix (text.bad_radix)
    );

    // Handshake outputs.
    assign number.ready = in_ready;
    assign text.valid   = out_valid;

endmodule

FILE: hdl/sirt_datapath.sv
// Datapath of the radix text converter: bit-serial restoring divider,
// digit store, digit counter and output character selection.
// Depends on sirt_pkg.
module sirt_datapath
    import sirt_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic        [RADIX_W-1:0]    radix,
    input  sirt_cmd_t                    cmd,
    output sirt_status_t                 status,
    output logic        [CHAR_W-1:0]     character,
    output logic                         last_char,
    output logic                         bad_radix
);
    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] value_u;
    logic [VALUE_BITS-1:0] magnitude;

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [DIGIT_W-1:0]    radix_reg, radix_next;
    logic [AW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [DIGIT_W-1:0]    rd_data_reg;

    logic [DIGIT_W:0]      trial;
    logic [DIGIT_W:0]      diff;
    logic                  ge;
    logic [DIGIT_W-1:0]    rem_new;
    logic [VALUE_BITS-1:0] quo_new;
    logic                  last_bit;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [CW-1:0]         cnt_minus_one;

    logic [DIGIT_W-1:0] digit_store [VALUE_BITS];

    // Magnitude of the input; the most negative value maps to 2^(VALUE_BITS-1).
    assign value_u   = value;
    assign magnitude = value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;

    // One restoring division step: shift in the next dividend bit and subtract.
    assign trial   = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign ge      = (trial >= {1'b0, radix_reg});
    assign diff    = trial - {1'b0, radix_reg};
    assign rem_new = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    assign quo_new = {quo_reg[VALUE_BITS-2:0], ge};

    assign last_bit      = (bit_cnt_reg == AW'(VALUE_BITS - 1));
    assign cnt_minus_one = cnt_reg - CW'(1);
    assign wr_addr       = cnt_reg[AW-1:0];
    assign rd_addr       = cnt_minus_one[AW-1:0];

    // Status toward the controller.
    always_comb
    begin
        status.in_bad   = (radix < RADIX_MIN) || (radix > RADIX_MAX);
        status.negative = neg_reg;
        status.last_bit = last_bit;
        status.quo_zero = (quo_new == '0);
        status.ptr_last = (cnt_reg == CW'(1));
    end

    // Next values of the divider and digit counter.
    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        radix_next   = radix_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        if (cmd.load)
        begin
            quo_next     = magnitude;
            rem_next     = '0;
            radix_next   = radix[DIGIT_W-1:0];
            bit_cnt_next = '0;
            cnt_next     = '0;
            neg_next     = value_u[VALUE_BITS-1];
        end
        else if (cmd.div_step)
        begin
            quo_next = quo_new;
            if (last_bit)
            begin
                rem_next     = '0;
                bit_cnt_next = '0;
                cnt_next     = cnt_reg + CW'(1);
            end
            else
            begin
                rem_next     = rem_new;
                bit_cnt_next = bit_cnt_reg + AW'(1);
            end
        end
        else if (cmd.ptr_dec)
        begin
            cnt_next = cnt_minus_one;
        end
    end

    // Control and arithmetic registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg     <= '0;
            rem_reg     <= '0;
            radix_reg   <= '0;
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
            neg_reg     <= 1'b0;
        end
        else
        begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            radix_reg   <= radix_next;
            bit_cnt_reg <= bit_cnt_next;
            cnt_reg     <= cnt_next;
            neg_reg     <= neg_next;
        end
    end

    // Digit store: a remainder is written at the end of each digit, read back
    // most significant first into a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && last_bit)
        begin
            digit_store[wr_addr] <= rem_new;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= digit_store[rd_addr];
        end
    end

    // Output character selection.
    always_comb
    begin
        case (cmd.out_sel)
            OUT_SEL_DIGIT:
            begin
                character = digit_char(rd_data_reg);
                last_char = (cnt_reg == CW'(1));
                bad_radix = 1'b0;
            end
            OUT_SEL_SIGN:
            begin
                character = ASCII_MINUS;
                last_char = 1'b0;
                bad_radix = 1'b0;
            end
            OUT_SEL_BAD:
            begin
                character = ASCII_NUL;
                last_char = 1'b1;
                bad_radix = 1'b1;
            end
            default:
            begin
                character = ASCII_NUL;
                last_char = 1'b0;
                bad_radix = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/sirt_ctrl.sv
// Controller of the radix text converter: sequences loading, division,
// digit read-back and the output handshake.
// Depends on sirt_pkg.
module sirt_ctrl
    import sirt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  sirt_status_t status,
    output sirt_cmd_t    cmd
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIVIDE = 6'b000010,
        ST_SIGN   = 6'b000100,
        ST_READ   = 6'b001000,
        ST_EMIT   = 6'b010000,
        ST_BAD    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.load    = 1'b0;
        cmd.div_step = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.ptr_dec = 1'b0;
        cmd.out_sel = OUT_SEL_DIGIT;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.in_bad ? ST_BAD : ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.last_bit && status.quo_zero)
                begin
                    state_next = status.negative ? ST_SIGN : ST_READ;
                end
            end
            ST_SIGN:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = OUT_SEL_SIGN;
                if (out_ready)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = OUT_SEL_DIGIT;
                if (out_ready)
                begin
                    cmd.ptr_dec = 1'b1;
                    state_next  = status.ptr_last ? ST_IDLE : ST_READ;
                end
            end
            ST_BAD:
            begin
                out_valid   = 1'b1;
                cmd.out_sel = OUT_SEL_BAD;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
